>>> rtl/core/statistical_moments_engine_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros used by the statistical moments engine controller.
// ----------------------------------------------------------------------------
`ifndef STATISTICAL_MOMENTS_ENGINE_MACROS_SVH
`define STATISTICAL_MOMENTS_ENGINE_MACROS_SVH

// Same-cycle implication check.
`define SMOM_ASSERT_IMP(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("smom same-cycle check failed");

// Next-cycle implication check.
`define SMOM_ASSERT_NXT(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("smom next-cycle check failed");

`endif

>>> rtl/core/smom_pkg.sv
// ----------------------------------------------------------------------------
// smom_pkg
// Types, constants and the compute program of the statistical moments engine.
// ----------------------------------------------------------------------------
package smom_pkg;

  // Sample and count sizing.
  localparam int SAMPLE_IN_W = 12;
  localparam int SAMPLE_BITS = 12;
  localparam int COUNT_BITS  = 16;

  // Accumulator widths, sized for a full set of extreme samples.
  localparam int SUM1_W = SAMPLE_BITS + COUNT_BITS + 1;
  localparam int SUM2_W = 2 * SAMPLE_BITS - 1 + COUNT_BITS;
  localparam int SUM3_W = 3 * SAMPLE_BITS - 2 + COUNT_BITS;
  localparam int SUM4_W = 4 * SAMPLE_BITS - 3 + COUNT_BITS;

  // Wide arithmetic unit.
  localparam int WIDE_W   = 192;
  localparam int MUL_BITS = 96;
  localparam int CNT_W    = $clog2(WIDE_W + 1);

  // Result field widths.
  localparam int OUT_S_W = 64;
  localparam int OUT_U_W = 63;

  // Program and register file addressing.
  localparam int REG_IDX_W = 4;
  localparam int REG_COUNT = 16;
  localparam int PC_W      = 6;
  localparam int IMM_W     = 17;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  // Status codes.
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_ZERO_VAR = 2'd1;
  localparam logic [1:0] STAT_CAP      = 2'd2;

  // Register file entries.
  localparam logic [REG_IDX_W-1:0] R_N  = 4'd0;
  localparam logic [REG_IDX_W-1:0] R_S1 = 4'd1;
  localparam logic [REG_IDX_W-1:0] R_S2 = 4'd2;
  localparam logic [REG_IDX_W-1:0] R_S3 = 4'd3;
  localparam logic [REG_IDX_W-1:0] R_S4 = 4'd4;
  localparam logic [REG_IDX_W-1:0] R_N2 = 4'd5;
  localparam logic [REG_IDX_W-1:0] R_N3 = 4'd6;
  localparam logic [REG_IDX_W-1:0] R_N4 = 4'd7;
  localparam logic [REG_IDX_W-1:0] R_T  = 4'd8;
  localparam logic [REG_IDX_W-1:0] R_X  = 4'd9;
  localparam logic [REG_IDX_W-1:0] R_A2 = 4'd10;
  localparam logic [REG_IDX_W-1:0] R_A3 = 4'd11;
  localparam logic [REG_IDX_W-1:0] R_A4 = 4'd12;
  localparam logic [REG_IDX_W-1:0] R_Y  = 4'd13;

  // Result field selectors for the output operation.
  localparam logic [REG_IDX_W-1:0] F_MEAN = 4'd0;
  localparam logic [REG_IDX_W-1:0] F_RAW2 = 4'd1;
  localparam logic [REG_IDX_W-1:0] F_RAW3 = 4'd2;
  localparam logic [REG_IDX_W-1:0] F_RAW4 = 4'd3;
  localparam logic [REG_IDX_W-1:0] F_C2   = 4'd4;
  localparam logic [REG_IDX_W-1:0] F_C3   = 4'd5;
  localparam logic [REG_IDX_W-1:0] F_C4   = 4'd6;
  localparam logic [REG_IDX_W-1:0] F_SKEW = 4'd7;
  localparam logic [REG_IDX_W-1:0] F_KURT = 4'd8;

  // Load sources and multiplier constants.
  localparam logic [IMM_W-1:0] SRC_N  = 17'd0;
  localparam logic [IMM_W-1:0] SRC_S1 = 17'd1;
  localparam logic [IMM_W-1:0] SRC_S2 = 17'd2;
  localparam logic [IMM_W-1:0] SRC_S3 = 17'd3;
  localparam logic [IMM_W-1:0] SRC_S4 = 17'd4;
  localparam logic [IMM_W-1:0] K_TWO   = 17'd2;
  localparam logic [IMM_W-1:0] K_THREE = 17'd3;
  localparam logic [IMM_W-1:0] K_FOUR  = 17'd4;
  localparam logic [IMM_W-1:0] K_SIX   = 17'd6;
  localparam logic [IMM_W-1:0] K_Q_ONE = 17'd65536;
  localparam logic [IMM_W-1:0] K_NONE  = 17'd0;

  typedef enum logic [3:0] {
    OP_LD, OP_MUL, OP_MULK, OP_ADD, OP_SUB, OP_DIV, OP_ZCHK, OP_OUT, OP_END
  } op_t;

  typedef enum logic [2:0] {
    ST_COLLECT, ST_DRAIN, ST_READ, ST_OPND, ST_EXEC, ST_WRITE, ST_PUBLISH
  } state_t;

  typedef struct packed {
    op_t                  op;
    logic [REG_IDX_W-1:0] dst;
    logic [REG_IDX_W-1:0] a;
    logic [REG_IDX_W-1:0] b;
    logic [IMM_W-1:0]     imm;
  } instr_t;

  // Controller to datapath.
  typedef struct packed {
    logic   rd_en;
    logic   start;
    logic   commit;
    logic   publish;
    logic   clear;
    instr_t ins;
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic unit_busy;
    logic pipe_busy;
  } dp_stat_t;

  typedef struct packed {
    logic signed [OUT_S_W-1:0] mean_value;
    logic        [OUT_U_W-1:0] raw_second;
    logic signed [OUT_S_W-1:0] raw_third;
    logic        [OUT_U_W-1:0] raw_fourth;
    logic signed [OUT_S_W-1:0] central_second;
    logic signed [OUT_S_W-1:0] central_third;
    logic signed [OUT_S_W-1:0] central_fourth;
    logic        [OUT_U_W-1:0] skewness_beta;
    logic signed [OUT_S_W-1:0] kurtosis_beta;
    logic [COUNT_BITS-1:0]     sample_count;
    logic [1:0]                status;
  } result_t;

  function automatic instr_t mk(input op_t op, input logic [REG_IDX_W-1:0] dst,
                                input logic [REG_IDX_W-1:0] a,
                                input logic [REG_IDX_W-1:0] b,
                                input logic [IMM_W-1:0] imm);
    instr_t r;
    r.op  = op;
    r.dst = dst;
    r.a   = a;
    r.b   = b;
    r.imm = imm;
    return r;
  endfunction

  // Compute program: central sums, then every quotient, then the end mark.
  function automatic instr_t prog_at(input logic [PC_W-1:0] pc);
    instr_t r;
    case (pc)
      6'd0:  r = mk(OP_LD,   R_N,  R_N,  R_N,  SRC_N);
      6'd1:  r = mk(OP_LD,   R_S1, R_N,  R_N,  SRC_S1);
      6'd2:  r = mk(OP_LD,   R_S2, R_N,  R_N,  SRC_S2);
      6'd3:  r = mk(OP_LD,   R_S3, R_N,  R_N,  SRC_S3);
      6'd4:  r = mk(OP_LD,   R_S4, R_N,  R_N,  SRC_S4);
      6'd5:  r = mk(OP_MUL,  R_N2, R_N,  R_N,  K_NONE);
      6'd6:  r = mk(OP_MUL,  R_N3, R_N2, R_N,  K_NONE);
      6'd7:  r = mk(OP_MUL,  R_N4, R_N3, R_N,  K_NONE);
      6'd8:  r = mk(OP_MUL,  R_T,  R_S1, R_S1, K_NONE);
      6'd9:  r = mk(OP_MUL,  R_X,  R_N,  R_S2, K_NONE);
      6'd10: r = mk(OP_SUB,  R_A2, R_X,  R_T,  K_NONE);
      6'd11: r = mk(OP_ZCHK, R_A2, R_A2, R_A2, K_NONE);
      6'd12: r = mk(OP_MUL,  R_A3, R_N2, R_S3, K_NONE);
      6'd13: r = mk(OP_MUL,  R_Y,  R_X,  R_S1, K_NONE);
      6'd14: r = mk(OP_MULK, R_Y,  R_Y,  R_Y,  K_THREE);
      6'd15: r = mk(OP_SUB,  R_A3, R_A3, R_Y,  K_NONE);
      6'd16: r = mk(OP_MUL,  R_Y,  R_T,  R_S1, K_NONE);
      6'd17: r = mk(OP_MULK, R_Y,  R_Y,  R_Y,  K_TWO);
      6'd18: r = mk(OP_ADD,  R_A3, R_A3, R_Y,  K_NONE);
      6'd19: r = mk(OP_MUL,  R_A4, R_N3, R_S4, K_NONE);
      6'd20: r = mk(OP_MUL,  R_Y,  R_N2, R_S3, K_NONE);
      6'd21: r = mk(OP_MUL,  R_Y,  R_Y,  R_S1, K_NONE);
      6'd22: r = mk(OP_MULK, R_Y,  R_Y,  R_Y,  K_FOUR);
      6'd23: r = mk(OP_SUB,  R_A4, R_A4, R_Y,  K_NONE);
      6'd24: r = mk(OP_MUL,  R_Y,  R_X,  R_T,  K_NONE);
      6'd25: r = mk(OP_MULK, R_Y,  R_Y,  R_Y,  K_SIX);
      6'd26: r = mk(OP_ADD,  R_A4, R_A4, R_Y,  K_NONE);
      6'd27: r = mk(OP_MUL,  R_Y,  R_T,  R_T,  K_NONE);
      6'd28: r = mk(OP_MULK, R_Y,  R_Y,  R_Y,  K_THREE);
      6'd29: r = mk(OP_SUB,  R_A4, R_A4, R_Y,  K_NONE);
      6'd30: r = mk(OP_MULK, R_Y,  R_S1, R_S1, K_Q_ONE);
      6'd31: r = mk(OP_DIV,  R_Y,  R_Y,  R_N,  K_NONE);
      6'd32: r = mk(OP_OUT,  F_MEAN, R_Y, R_Y, K_NONE);
      6'd33: r = mk(OP_MULK, R_Y,  R_S2, R_S2, K_Q_ONE);
      6'd34: r = mk(OP_DIV,  R_Y,  R_Y,  R_N,  K_NONE);
      6'd35: r = mk(OP_OUT,  F_RAW2, R_Y, R_Y, K_NONE);
      6'd36: r = mk(OP_MULK, R_Y,  R_S3, R_S3, K_Q_ONE);
      6'd37: r = mk(OP_DIV,  R_Y,  R_Y,  R_N,  K_NONE);
      6'd38: r = mk(OP_OUT,  F_RAW3, R_Y, R_Y, K_NONE);
      6'd39: r = mk(OP_MULK, R_Y,  R_S4, R_S4, K_Q_ONE);
      6'd40: r = mk(OP_DIV,  R_Y,  R_Y,  R_N,  K_NONE);
      6'd41: r = mk(OP_OUT,  F_RAW4, R_Y, R_Y, K_NONE);
      6'd42: r = mk(OP_MULK, R_Y,  R_A2, R_A2, K_Q_ONE);
      6'd43: r = mk(OP_DIV,  R_Y,  R_Y,  R_N2, K_NONE);
      6'd44: r = mk(OP_OUT,  F_C2, R_Y,  R_Y,  K_NONE);
      6'd45: r = mk(OP_MULK, R_Y,  R_A3, R_A3, K_Q_ONE);
      6'd46: r = mk(OP_DIV,  R_Y,  R_Y,  R_N3, K_NONE);
      6'd47: r = mk(OP_OUT,  F_C3, R_Y,  R_Y,  K_NONE);
      6'd48: r = mk(OP_MULK, R_Y,  R_A4, R_A4, K_Q_ONE);
      6'd49: r = mk(OP_DIV,  R_Y,  R_Y,  R_N4, K_NONE);
      6'd50: r = mk(OP_OUT,  F_C4, R_Y,  R_Y,  K_NONE);
      6'd51: r = mk(OP_MUL,  R_Y,  R_A3, R_A3, K_NONE);
      6'd52: r = mk(OP_MULK, R_Y,  R_Y,  R_Y,  K_Q_ONE);
      6'd53: r = mk(OP_MUL,  R_X,  R_A2, R_A2, K_NONE);
      6'd54: r = mk(OP_MUL,  R_X,  R_X,  R_A2, K_NONE);
      6'd55: r = mk(OP_DIV,  R_Y,  R_Y,  R_X,  K_NONE);
      6'd56: r = mk(OP_OUT,  F_SKEW, R_Y, R_Y, K_NONE);
      6'd57: r = mk(OP_MULK, R_Y,  R_A4, R_A4, K_Q_ONE);
      6'd58: r = mk(OP_MUL,  R_X,  R_A2, R_A2, K_NONE);
      6'd59: r = mk(OP_DIV,  R_Y,  R_Y,  R_X,  K_NONE);
      6'd60: r = mk(OP_OUT,  F_KURT, R_Y, R_Y, K_NONE);
      default: r = mk(OP_END, R_N, R_N, R_N, K_NONE);
    endcase
    return r;
  endfunction

endpackage

>>> rtl/core/smom_if.sv
// ----------------------------------------------------------------------------
// smom_in_if / smom_out_if
// Valid/ready channels for samples and for finished results.
// ----------------------------------------------------------------------------
interface smom_in_if;
  import smom_pkg::*;
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_IN_W-1:0] sample;
  logic                          last_sample;
  modport source (output valid, output sample, output last_sample, input ready);
  modport sink (input valid, input sample, input last_sample, output ready);
endinterface

interface smom_out_if;
  import smom_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [OUT_S_W-1:0] mean_value;
  logic        [OUT_U_W-1:0] raw_second;
  logic signed [OUT_S_W-1:0] raw_third;
  logic        [OUT_U_W-1:0] raw_fourth;
  logic signed [OUT_S_W-1:0] central_second;
  logic signed [OUT_S_W-1:0] central_third;
  logic signed [OUT_S_W-1:0] central_fourth;
  logic        [OUT_U_W-1:0] skewness_beta;
  logic signed [OUT_S_W-1:0] kurtosis_beta;
  logic [COUNT_BITS-1:0]     sample_count;
  logic [1:0]                status;
  modport source (output valid, output mean_value, output raw_second, output raw_third,
                  output raw_fourth, output central_second, output central_third,
                  output central_fourth, output skewness_beta, output kurtosis_beta,
                  output sample_count, output status, input ready);
  modport sink (input valid, input mean_value, input raw_second, input raw_third,
                input raw_fourth, input central_second, input central_third,
                input central_fourth, input skewness_beta, input kurtosis_beta,
                input sample_count, input status, output ready);
endinterface

>>> rtl/core/statistical_moments_engine.sv
// ----------------------------------------------------------------------------
// statistical_moments_engine
// Raw and central moments, skewness and kurtosis of a marked sample set.
//
//   channel   dir  beat contents
//   samples   in   sample, last_sample
//   results   out  nine moments (Q48.16 signed, UQ47.16 unsigned), sample_count, status
//
// Samples are taken one per cycle while a set is being collected. After the
// marked beat the power pipeline drains, then the program runs on one shared
// shift-add multiplier and one restoring divider. No samples are taken during
// that time; the result register frees the input for the next set while its
// beat waits. Reset is synchronous and clears the sums, count and control;
// there is no clearing pass.
// ----------------------------------------------------------------------------
module statistical_moments_engine (
  input logic        clk,
  input logic        rst,
  smom_in_if.sink    samples,
  smom_out_if.source results
);
  import smom_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  result_t  res;
  logic     accept;

  assign accept = samples.valid && samples.ready;

  smom_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (samples.valid),
    .in_last   (samples.last_sample),
    .in_ready  (samples.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  smom_dpath u_dpath (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .sample (samples.sample),
    .cmd    (cmd),
    .stat   (stat),
    .res    (res)
  );

  // Result fields.
  assign results.mean_value     = res.mean_value;
  assign results.raw_second     = res.raw_second;
  assign results.raw_third      = res.raw_third;
  assign results.raw_fourth     = res.raw_fourth;
  assign results.central_second = res.central_second;
  assign results.central_third  = res.central_third;
  assign results.central_fourth = res.central_fourth;
  assign results.skewness_beta  = res.skewness_beta;
  assign results.kurtosis_beta  = res.kurtosis_beta;
  assign results.sample_count   = res.sample_count;
  assign results.status         = res.status;

endmodule

>>> rtl/core/smom_accum.sv
// ----------------------------------------------------------------------------
// smom_accum
// Power pipeline and running sums of x, x^2, x^3 and x^4 with sample count.
// ----------------------------------------------------------------------------
module smom_accum (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 accept,
  input  logic [smom_pkg::SAMPLE_IN_W-1:0]     sample,
  input  logic                                 clear,
  output logic signed [smom_pkg::SUM1_W-1:0]   sum1,
  output logic [smom_pkg::SUM2_W-1:0]          sum2,
  output logic signed [smom_pkg::SUM3_W-1:0]   sum3,
  output logic [smom_pkg::SUM4_W-1:0]          sum4,
  output logic [smom_pkg::COUNT_BITS-1:0]      count,
  output logic                                 cap_hit,
  output logic                                 busy
);
  import smom_pkg::*;

  logic signed [SAMPLE_BITS-1:0]   x_in;
  logic signed [2*SAMPLE_BITS-1:0] sq_in;
  logic                            p1_v, p2_v;
  logic signed [SAMPLE_BITS-1:0]   p1_x, p2_x;
  logic signed [2*SAMPLE_BITS-1:0] p1_sq, p2_sq;
  logic signed [3*SAMPLE_BITS-1:0] cube_c, p2_cube;
  logic signed [4*SAMPLE_BITS-1:0] quad_c, p2_quad;

  // Low sample bits taken as a signed value.
  assign x_in   = $signed(sample[SAMPLE_BITS-1:0]);
  assign sq_in  = x_in * x_in;
  assign cube_c = p1_sq * p1_x;
  assign quad_c = p1_sq * p1_sq;
  assign busy   = p1_v | p2_v;

  // Count, capacity flag and pipeline valid bits.
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      count   <= '0;
      cap_hit <= 1'b0;
      p1_v    <= 1'b0;
      p2_v    <= 1'b0;
    end else begin
      p1_v <= 1'b0;
      p2_v <= p1_v;
      if (accept) begin
        if (count != COUNT_MAX) begin
          count <= count + 1'b1;
          p1_v  <= 1'b1;
        end else begin
          cap_hit <= 1'b1;
        end
      end
    end
  end

  // Power stages.
  always_ff @(posedge clk) begin
    p1_x    <= x_in;
    p1_sq   <= sq_in;
    p2_x    <= p1_x;
    p2_sq   <= p1_sq;
    p2_cube <= cube_c;
    p2_quad <= quad_c;
  end

  // Running sums.
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      sum1 <= '0;
      sum2 <= '0;
      sum3 <= '0;
      sum4 <= '0;
    end else if (p2_v) begin
      sum1 <= sum1 + SUM1_W'(p2_x);
      sum2 <= sum2 + SUM2_W'($unsigned(p2_sq));
      sum3 <= sum3 + SUM3_W'(p2_cube);
      sum4 <= sum4 + SUM4_W'($unsigned(p2_quad));
    end
  end

endmodule

>>> rtl/core/smom_dpath.sv
// ----------------------------------------------------------------------------
// smom_dpath
// Register file, shared shift-add multiplier and restoring divider, result
// staging and the output register.
// ----------------------------------------------------------------------------
module smom_dpath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 accept,
  input  logic [smom_pkg::SAMPLE_IN_W-1:0]     sample,
  input  smom_pkg::dp_cmd_t                    cmd,
  output smom_pkg::dp_stat_t                   stat,
  output smom_pkg::result_t                    res
);
  import smom_pkg::*;

  logic signed [SUM1_W-1:0] sum1;
  logic [SUM2_W-1:0]        sum2;
  logic signed [SUM3_W-1:0] sum3;
  logic [SUM4_W-1:0]        sum4;
  logic [COUNT_BITS-1:0]    count;
  logic                     cap_hit;
  logic                     pipe_busy;

  logic [WIDE_W-1:0] rf [REG_COUNT];
  logic [WIDE_W-1:0] opa, opb, bsrc, abs_a, abs_b;
  logic [WIDE_W-1:0] wr_data, unit_res;
  logic              wr_rf, is_unit;

  logic              busy, div_mode, neg, dz;
  logic [CNT_W-1:0]  cnt;
  logic [WIDE_W-1:0] u_a, u_b, u_acc, rem_sh;
  logic              ge;

  logic    zero_var;
  result_t stage;

  smom_accum u_accum (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .sample  (sample),
    .clear   (cmd.clear),
    .sum1    (sum1),
    .sum2    (sum2),
    .sum3    (sum3),
    .sum4    (sum4),
    .count   (count),
    .cap_hit (cap_hit),
    .busy    (pipe_busy)
  );

  assign stat.unit_busy = busy;
  assign stat.pipe_busy = pipe_busy;

  function automatic logic [OUT_S_W-1:0] sat_s64(input logic [WIDE_W-1:0] v);
    logic [WIDE_W-OUT_S_W:0] hi;
    hi = v[WIDE_W-1:OUT_S_W-1];
    if ((&hi) || !(|hi)) return v[OUT_S_W-1:0];
    else if (v[WIDE_W-1]) return {1'b1, {(OUT_S_W-1){1'b0}}};
    else return {1'b0, {(OUT_S_W-1){1'b1}}};
  endfunction

  function automatic logic [OUT_U_W-1:0] sat_u63(input logic [WIDE_W-1:0] v);
    if (v[WIDE_W-1]) return '0;
    else if (|v[WIDE_W-1:OUT_U_W]) return {OUT_U_W{1'b1}};
    else return v[OUT_U_W-1:0];
  endfunction

  // Register file with registered reads.
  always_ff @(posedge clk) begin
    if (wr_rf) begin
      rf[cmd.ins.dst] <= wr_data;
    end
    if (cmd.rd_en) begin
      opa <= rf[cmd.ins.a];
      opb <= rf[cmd.ins.b];
    end
  end

  // Operand magnitudes for the shared unit.
  assign is_unit = (cmd.ins.op == OP_MUL) || (cmd.ins.op == OP_MULK) ||
                   (cmd.ins.op == OP_DIV);
  assign bsrc    = (cmd.ins.op == OP_MULK) ? WIDE_W'(cmd.ins.imm) : opb;
  assign abs_a   = opa[WIDE_W-1] ? -opa : opa;
  assign abs_b   = bsrc[WIDE_W-1] ? -bsrc : bsrc;

  // One restoring divide step.
  assign rem_sh = {u_acc[WIDE_W-2:0], u_a[WIDE_W-1]};
  assign ge     = (rem_sh >= u_b);

  // Unit control.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (cmd.start && is_unit) begin
      busy <= 1'b1;
      cnt  <= (cmd.ins.op == OP_DIV) ? CNT_W'(WIDE_W) : CNT_W'(MUL_BITS);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Unit operands: shift-add multiply or one quotient bit per cycle.
  always_ff @(posedge clk) begin
    if (cmd.start && is_unit) begin
      u_acc <= '0;
      if (cmd.ins.op == OP_DIV) begin
        div_mode <= 1'b1;
        u_a      <= abs_a;
        u_b      <= abs_b;
        neg      <= opa[WIDE_W-1] ^ opb[WIDE_W-1];
        dz       <= (opb == '0);
      end else begin
        div_mode <= 1'b0;
        u_a      <= opa;
        u_b      <= abs_b;
        neg      <= bsrc[WIDE_W-1];
        dz       <= 1'b0;
      end
    end else if (busy) begin
      if (div_mode) begin
        u_acc <= ge ? (rem_sh - u_b) : rem_sh;
        u_a   <= {u_a[WIDE_W-2:0], ge};
      end else begin
        if (u_b[0]) begin
          u_acc <= u_acc + u_a;
        end
        u_a <= {u_a[WIDE_W-2:0], 1'b0};
        u_b <= {1'b0, u_b[WIDE_W-1:1]};
      end
    end
  end

  // Signed unit result; a zero divisor gives zero.
  always_comb begin
    if (div_mode) begin
      if (dz) unit_res = '0;
      else unit_res = neg ? -u_a : u_a;
    end else begin
      unit_res = neg ? -u_acc : u_acc;
    end
  end

  // Write-back value.
  always_comb begin
    wr_rf   = 1'b0;
    wr_data = '0;
    case (cmd.ins.op)
      OP_LD: begin
        wr_rf = cmd.commit;
        case (cmd.ins.imm)
          SRC_N:   wr_data = WIDE_W'(count);
          SRC_S1:  wr_data = WIDE_W'(sum1);
          SRC_S2:  wr_data = WIDE_W'(sum2);
          SRC_S3:  wr_data = WIDE_W'(sum3);
          SRC_S4:  wr_data = WIDE_W'(sum4);
          default: wr_data = '0;
        endcase
      end
      OP_MUL, OP_MULK, OP_DIV: begin
        wr_rf   = cmd.commit;
        wr_data = unit_res;
      end
      OP_ADD: begin
        wr_rf   = cmd.commit;
        wr_data = opa + opb;
      end
      OP_SUB: begin
        wr_rf   = cmd.commit;
        wr_data = opa - opb;
      end
      default: begin
        wr_rf   = 1'b0;
        wr_data = '0;
      end
    endcase
  end

  // Zero-variance flag and saturated result staging.
  always_ff @(posedge clk) begin
    if (cmd.commit && cmd.ins.op == OP_ZCHK) begin
      zero_var <= (opa == '0);
    end
    if (cmd.commit && cmd.ins.op == OP_OUT) begin
      case (cmd.ins.dst)
        F_MEAN:  stage.mean_value     <= sat_s64(opa);
        F_RAW2:  stage.raw_second     <= sat_u63(opa);
        F_RAW3:  stage.raw_third      <= sat_s64(opa);
        F_RAW4:  stage.raw_fourth     <= sat_u63(opa);
        F_C2:    stage.central_second <= sat_s64(opa);
        F_C3:    stage.central_third  <= sat_s64(opa);
        F_C4:    stage.central_fourth <= sat_s64(opa);
        F_SKEW:  stage.skewness_beta  <= sat_u63(opa);
        F_KURT:  stage.kurtosis_beta  <= sat_s64(opa);
        default: begin
        end
      endcase
    end
  end

  // Output register, loaded once the staged set is complete.
  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      res.mean_value     <= stage.mean_value;
      res.raw_second     <= stage.raw_second;
      res.raw_third      <= stage.raw_third;
      res.raw_fourth     <= stage.raw_fourth;
      res.central_second <= stage.central_second;
      res.central_third  <= stage.central_third;
      res.central_fourth <= stage.central_fourth;
      res.skewness_beta  <= stage.skewness_beta;
      res.kurtosis_beta  <= stage.kurtosis_beta;
      res.sample_count   <= count;
      if (cap_hit) res.status <= STAT_CAP;
      else if (zero_var) res.status <= STAT_ZERO_VAR;
      else res.status <= STAT_OK;
    end
  end

endmodule

>>> rtl/core/smom_ctrl.sv
// ----------------------------------------------------------------------------
// smom_ctrl
// Sequencer: sample collection, pipeline drain, program stepping and result
// handoff to the output register.
// ----------------------------------------------------------------------------
`include "statistical_moments_engine_macros.svh"

module smom_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_last,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output smom_pkg::dp_cmd_t   cmd,
  input  smom_pkg::dp_stat_t  stat
);
  import smom_pkg::*;

  state_t          state, state_next;
  logic [PC_W-1:0] pc;
  instr_t          ins;
  logic            slot_free;

  assign ins       = prog_at(pc);
  assign slot_free = !out_valid || out_ready;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_COLLECT: if (in_valid && in_last) state_next = ST_DRAIN;
      ST_DRAIN:   if (!stat.pipe_busy) state_next = ST_READ;
      ST_READ:    state_next = (ins.op == OP_END) ? ST_PUBLISH : ST_OPND;
      ST_OPND:    state_next = ST_EXEC;
      ST_EXEC:    if (!stat.unit_busy) state_next = ST_WRITE;
      ST_WRITE:   state_next = ST_READ;
      ST_PUBLISH: if (slot_free) state_next = ST_COLLECT;
      default:    state_next = ST_COLLECT;
    endcase
  end

  // Outputs.
  always_comb begin
    in_ready    = (state == ST_COLLECT);
    cmd.rd_en   = (state == ST_READ);
    cmd.start   = (state == ST_OPND);
    cmd.commit  = (state == ST_WRITE);
    cmd.publish = (state == ST_PUBLISH) && slot_free;
    cmd.clear   = (state == ST_PUBLISH) && slot_free;
    cmd.ins     = ins;
  end

  // State, program counter and result valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_COLLECT;
      pc        <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_DRAIN) pc <= '0;
      else if (state == ST_WRITE) pc <= pc + 1'b1;
      if (cmd.publish) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  `SMOM_ASSERT_IMP(a_pub_slot, clk, rst, cmd.publish, (!out_valid || out_ready))
  `SMOM_ASSERT_NXT(a_pub_valid, clk, rst, cmd.publish, out_valid)
  `SMOM_ASSERT_NXT(a_drain_start, clk, rst, (state == ST_DRAIN && !stat.pipe_busy), (state == ST_READ && pc == '0))

endmodule
